// ===== hdl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg: shared types and constants of the RC4 keystream cipher
// Request codes, table geometry and the operand bundle of the shared adder.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned TABLE_AW   = 8;
  localparam int unsigned KEYLEN_W   = 9;
  localparam int unsigned REQ_W      = 2;

  localparam logic [KEYLEN_W-1:0] KEYLEN_RESET = 9'd16;

  localparam logic [REQ_W-1:0] REQ_LOAD_KEY = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REKEY    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DATA     = 2'd2;

  // Operands of the shared three-input byte adder.
  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
  } alu_op_t;

endpackage

// ===== hdl/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// rc4_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/rc4_alu.sv =====
// ----------------------------------------------------------------------------
// rc4_alu: shared byte adder
// Modulo-256 sum of three bytes, used for index updates and table lookups.
// ----------------------------------------------------------------------------
module rc4_alu (
  input  rc4_pkg::alu_op_t                op_i,
  output logic [rc4_pkg::BYTE_W-1:0]      sum_o
);

  assign sum_o = op_i.a + op_i.b + op_i.c;

endmodule

// ===== hdl/rc4_keystream_cipher_top.sv =====
// ----------------------------------------------------------------------------
// rc4_keystream_cipher_top: RC4 stream cipher with key store
// After reset the permutation table is filled with the identity, one entry a
// cycle; no word is accepted meanwhile (configuration is). A key byte load
// goes straight to the result stage, a data byte first passes the table RAM
// steps from IDLE through DATA_RJ, DATA_WI and DATA_WJ, and a rekey first
// runs the identity fill and then the key schedule, all paced by the single
// table RAM write port. One word is in flight at a time.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher_top #(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] key_index, [15:8] value
  input  logic [2:0]  s_axis_tuser,  // [1:0] req_type, [2] new_message
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] data_out
  output logic [0:0]  m_axis_tuser,  // [0] keyed
  // Key length register write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i
);

  localparam int unsigned KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [rc4_pkg::KEYLEN_W-1:0] KEY_MAX = rc4_pkg::KEYLEN_W'(MAX_KEY_BYTES);
  localparam logic [rc4_pkg::TABLE_AW-1:0] LAST_ENTRY =
    rc4_pkg::TABLE_AW'(rc4_pkg::TABLE_SIZE - 1);

  // The sequencer. INIT writes the identity permutation; the KEY states run
  // one key schedule step, the DATA states one generator step.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_J,
    ST_KEY_WK,
    ST_KEY_WJ,
    ST_DATA_RJ,
    ST_DATA_WI,
    ST_DATA_WJ,
    ST_DONE
  } state_e;

  state_e                                state_q;
  logic                                  rekey_q;
  logic [rc4_pkg::TABLE_AW-1:0]          k_q;
  logic [KW-1:0]                         kk_q;
  logic [rc4_pkg::BYTE_W-1:0]            i_q;
  logic [rc4_pkg::BYTE_W-1:0]            j_q;
  logic [rc4_pkg::BYTE_W-1:0]            si_q;
  logic [rc4_pkg::BYTE_W-1:0]            sj_q;
  logic [rc4_pkg::BYTE_W-1:0]            t_q;
  logic [rc4_pkg::BYTE_W-1:0]            data_q;
  logic [rc4_pkg::BYTE_W-1:0]            res_q;
  logic                                  keyed_q;
  logic [rc4_pkg::KEYLEN_W-1:0]          key_length_q;

  logic [rc4_pkg::REQ_W-1:0]             in_req;
  logic [rc4_pkg::BYTE_W-1:0]            in_kidx;
  logic [rc4_pkg::BYTE_W-1:0]            in_value;
  logic                                  in_new;
  logic                                  in_accept;

  rc4_pkg::alu_op_t                      alu_op;
  logic [rc4_pkg::BYTE_W-1:0]            alu_sum;

  logic                                  s_we;
  logic [rc4_pkg::TABLE_AW-1:0]          s_waddr;
  logic [rc4_pkg::BYTE_W-1:0]            s_wdata;
  logic [rc4_pkg::TABLE_AW-1:0]          s_raddr;
  logic [rc4_pkg::BYTE_W-1:0]            s_rdata;

  logic                                  k_we;
  logic [rc4_pkg::BYTE_W-1:0]            k_rdata;

  logic [rc4_pkg::KEYLEN_W-1:0]          key_len_eff;
  logic                                  kk_wrap;
  logic [rc4_pkg::BYTE_W-1:0]            ks_byte;

  assign in_kidx   = s_axis_tdata[7:0];
  assign in_value  = s_axis_tdata[15:8];
  assign in_req    = s_axis_tuser[1:0];
  assign in_new    = s_axis_tuser[2];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // A key length of zero counts as one, anything above the store depth as the
  // full store.
  always_comb begin
    if (key_length_q == '0) begin
      key_len_eff = rc4_pkg::KEYLEN_W'(1);
    end else if (key_length_q > KEY_MAX) begin
      key_len_eff = KEY_MAX;
    end else begin
      key_len_eff = key_length_q;
    end
  end

  assign kk_wrap = (rc4_pkg::KEYLEN_W'(kk_q) + rc4_pkg::KEYLEN_W'(1)) >= key_len_eff;

  // Operand selection for the shared adder. While idle it forms the next i,
  // which also addresses the first table read of a data word.
  always_comb begin
    alu_op.a = (in_new) ? '0 : i_q;
    alu_op.b = rc4_pkg::BYTE_W'(1);
    alu_op.c = '0;
    case (state_q)
      ST_KEY_J: begin
        alu_op.a = j_q;
        alu_op.b = s_rdata;
        alu_op.c = k_rdata;
      end
      ST_DATA_RJ: begin
        alu_op.a = j_q;
        alu_op.b = s_rdata;
      end
      ST_DATA_WI: begin
        alu_op.a = si_q;
        alu_op.b = s_rdata;
      end
      default: ;
    endcase
  end

  rc4_alu u_alu (
    .op_i  (alu_op),
    .sum_o (alu_sum)
  );

  // Permutation table port control. The key schedule keeps S[k] in si_q, the
  // same holding register the data path uses for S[i].
  always_comb begin
    s_we    = 1'b0;
    s_waddr = k_q;
    s_wdata = k_q;
    s_raddr = k_q;
    case (state_q)
      ST_INIT: begin
        s_we = 1'b1;
      end
      ST_IDLE, ST_KEY_J, ST_DATA_RJ, ST_DATA_WI: begin
        s_raddr = alu_sum;
      end
      default: ;
    endcase
    case (state_q)
      ST_KEY_WK: begin
        s_we    = 1'b1;
        s_waddr = k_q;
        s_wdata = s_rdata;
      end
      ST_KEY_WJ: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
      end
      ST_DATA_WI: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = s_rdata;
      end
      ST_DATA_WJ: begin
        s_we    = 1'b1;
        s_waddr = j_q;
        s_wdata = si_q;
      end
      default: ;
    endcase
  end

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::TABLE_SIZE)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // Key store: written straight from an accepted load word, read by the key
  // schedule at the cycling key position.
  assign k_we = in_accept && (in_req == rc4_pkg::REQ_LOAD_KEY) &&
                (rc4_pkg::KEYLEN_W'(in_kidx) < KEY_MAX);

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (MAX_KEY_BYTES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (k_we),
    .waddr_i (in_kidx[KW-1:0]),
    .wdata_i (in_value),
    .raddr_i (kk_q),
    .rdata_o (k_rdata)
  );

  // The keystream read at t was issued in the same cycle as the write of
  // S[i], so a hit on either swapped entry takes the swapped value; S[j] was
  // written last and wins when i equals j.
  always_comb begin
    if (t_q == j_q) begin
      ks_byte = si_q;
    end else if (t_q == i_q) begin
      ks_byte = sj_q;
    end else begin
      ks_byte = s_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      rekey_q       <= 1'b0;
      k_q           <= '0;
      kk_q          <= '0;
      i_q           <= '0;
      j_q           <= '0;
      si_q          <= '0;
      sj_q          <= '0;
      t_q           <= '0;
      data_q        <= '0;
      res_q         <= '0;
      keyed_q       <= 1'b0;
      key_length_q  <= rc4_pkg::KEYLEN_RESET;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= '0;
    end else begin
      if (cfg_valid_i) begin
        key_length_q <= cfg_data_i;
      end
      // The result stage reloads the output itself when it fires.
      if (m_axis_tready && (state_q != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        ST_INIT: begin
          k_q <= k_q + rc4_pkg::TABLE_AW'(1);
          if (k_q == LAST_ENTRY) begin
            j_q  <= '0;
            kk_q <= '0;
            state_q <= (rekey_q) ? ST_KEY_RD : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            data_q <= in_value;
            res_q  <= '0;
            case (in_req)
              rc4_pkg::REQ_REKEY: begin
                rekey_q <= 1'b1;
                state_q <= ST_INIT;
              end
              rc4_pkg::REQ_DATA: begin
                i_q     <= alu_sum;
                j_q     <= (in_new) ? '0 : j_q;
                state_q <= ST_DATA_RJ;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_KEY_RD: begin
          state_q <= ST_KEY_J;
        end
        ST_KEY_J: begin
          si_q    <= s_rdata;
          j_q     <= alu_sum;
          state_q <= ST_KEY_WK;
        end
        ST_KEY_WK: begin
          state_q <= ST_KEY_WJ;
        end
        ST_KEY_WJ: begin
          k_q  <= k_q + rc4_pkg::TABLE_AW'(1);
          kk_q <= (kk_wrap) ? '0 : kk_q + KW'(1);
          if (k_q == LAST_ENTRY) begin
            i_q     <= '0;
            j_q     <= '0;
            keyed_q <= 1'b1;
            rekey_q <= 1'b0;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_KEY_RD;
          end
        end
        ST_DATA_RJ: begin
          si_q    <= s_rdata;
          j_q     <= alu_sum;
          state_q <= ST_DATA_WI;
        end
        ST_DATA_WI: begin
          sj_q    <= s_rdata;
          t_q     <= alu_sum;
          state_q <= ST_DATA_WJ;
        end
        ST_DATA_WJ: begin
          res_q   <= data_q ^ ks_byte;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid   <= 1'b1;
            m_axis_tdata    <= res_q;
            m_axis_tuser[0] <= keyed_q;
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Once keyed, the block stays keyed until the next reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(keyed_q))
    else $error("keyed flag dropped");

  // A new result only ever comes out of the result stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the result stage");

  // The index i holds through the swap of a generator step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA_WJ) |-> $stable(i_q))
    else $error("index i moved during the swap");

  // A rekey word always enters the identity fill.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_req == rc4_pkg::REQ_REKEY) |=> (state_q == ST_INIT && k_q == '0))
    else $error("rekey did not start the table fill");

endmodule

// ===== test/tb_rc4_keystream_cipher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc4_keystream_cipher_top: self-checking bench for the RC4 stream cipher
// Drives key loads, rekeys and data bytes over the input stream and keeps its
// own copy of the permutation, indices and key store. Every accepted word is
// predicted on acceptance and every result word is checked in order.
// ----------------------------------------------------------------------------
module tb_rc4_keystream_cipher_top;

  localparam int unsigned KEY_STORE_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  // The fourth request code is unused; the block must answer it with zero.
  localparam logic [rc4_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  // One result word: data_out and the keyed flag.
  typedef struct packed {
    logic [rc4_pkg::BYTE_W-1:0] data_out;
    logic                       keyed;
  } rc4_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;  // [7:0] key_index, [15:8] value
  logic [2:0]  s_axis_tuser;  // [1:0] req_type, [2] new_message
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;  // [7:0] data_out
  logic [0:0]  m_axis_tuser;  // [0] keyed
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i;

  // Predicted cipher state, kept in step with every accepted word.
  logic [rc4_pkg::BYTE_W-1:0]   sbox [rc4_pkg::TABLE_SIZE];
  logic [rc4_pkg::BYTE_W-1:0]   key_bytes [KEY_STORE_DEPTH];
  bit                           key_loaded [KEY_STORE_DEPTH];
  logic [rc4_pkg::BYTE_W-1:0]   ptr_i;
  logic [rc4_pkg::BYTE_W-1:0]   ptr_j;
  logic                         is_keyed;
  logic [rc4_pkg::KEYLEN_W-1:0] key_len;

  // Results still owed by the block, oldest first.
  rc4_result_t pending_results [$];
  rc4_result_t want;

  // When set, neither side of the block idles.
  bit          steady_flow;
  int unsigned words_sent;
  int unsigned errors;
  int unsigned cycle_count;

  rc4_keystream_cipher_top #(
    .MAX_KEY_BYTES(KEY_STORE_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run guard: a stuck handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_rc4_keystream_cipher_top: FAIL");
      $finish;
    end
  end

  // The result side stalls in about one cycle of five unless the flow is
  // steady. It changes on the falling edge, away from the sampling edge.
  always @(negedge clk_i) begin
    m_axis_tready = steady_flow || ($urandom_range(99) >= 19);
  end

  // Result checker. Values read right after the rising edge are the ones
  // that the edge sampled, so the comparison does not race the block.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected: data_out %h keyed %b",
                 $time, m_axis_tdata, m_axis_tuser[0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.data_out) begin
          $display("%0t: data_out mismatch: expected %h actual %h",
                   $time, want.data_out, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== want.keyed) begin
          $display("%0t: keyed mismatch: expected %b actual %b",
                   $time, want.keyed, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  // A register value of zero acts as one byte, anything above the store
  // depth as the whole store.
  function automatic int unsigned active_key_len();
    if (key_len == '0) return 1;
    if (key_len > KEY_STORE_DEPTH) return KEY_STORE_DEPTH;
    return int'(key_len);
  endfunction

  // Key schedule: always starts from the identity and cycles the key bytes.
  function automatic void schedule_permutation();
    int unsigned                n;
    logic [rc4_pkg::BYTE_W-1:0] j;
    logic [rc4_pkg::BYTE_W-1:0] t;
    n = active_key_len();
    for (int k = 0; k < rc4_pkg::TABLE_SIZE; k++) sbox[k] = 8'(k);
    j = '0;
    for (int k = 0; k < rc4_pkg::TABLE_SIZE; k++) begin
      j = j + sbox[k] + key_bytes[k % n];
      t = sbox[k];
      sbox[k] = sbox[j];
      sbox[j] = t;
    end
    ptr_i    = '0;
    ptr_j    = '0;
    is_keyed = 1'b1;
  endfunction

  // One generator step: advance both indices, swap, read the keystream byte.
  function automatic logic [rc4_pkg::BYTE_W-1:0] advance_keystream();
    logic [rc4_pkg::BYTE_W-1:0] t;
    logic [rc4_pkg::BYTE_W-1:0] sum;
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + sbox[ptr_i];
    t = sbox[ptr_i];
    sbox[ptr_i] = sbox[ptr_j];
    sbox[ptr_j] = t;
    sum = sbox[ptr_i] + sbox[ptr_j];
    return sbox[sum];
  endfunction

  // Applies one accepted word to the predicted state and returns its result.
  function automatic rc4_result_t predict_rc4_word(
    input logic [rc4_pkg::REQ_W-1:0]  req,
    input logic [rc4_pkg::BYTE_W-1:0] kidx,
    input logic [rc4_pkg::BYTE_W-1:0] val,
    input logic                       fresh
  );
    rc4_result_t res;
    res.data_out = '0;
    case (req)
      rc4_pkg::REQ_LOAD_KEY: begin
        key_bytes[kidx]  = val;
        key_loaded[kidx] = 1'b1;
      end
      rc4_pkg::REQ_REKEY: begin
        schedule_permutation();
      end
      rc4_pkg::REQ_DATA: begin
        if (fresh) begin
          ptr_i = '0;
          ptr_j = '0;
        end
        res.data_out = val ^ advance_keystream();
      end
      default: begin
      end
    endcase
    res.keyed = is_keyed;
    return res;
  endfunction

  // Presents one word on the input stream, optionally after an idle gap,
  // and records its expected result once the block has taken it.
  task automatic send_word(input logic [rc4_pkg::REQ_W-1:0]  req,
                           input logic [rc4_pkg::BYTE_W-1:0] kidx,
                           input logic [rc4_pkg::BYTE_W-1:0] val,
                           input logic                       fresh);
    int unsigned gap;
    gap = 0;
    if (!steady_flow && $urandom_range(99) < 19) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {val, kidx};
    s_axis_tuser  = {fresh, req};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_rc4_word(req, kidx, val, fresh));
    if (req != REQ_UNUSED) words_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Waits until every expected result has come back, then a little longer.
  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes the key length register while the block is idle.
  task automatic write_key_length(input logic [rc4_pkg::KEYLEN_W-1:0] len);
    drain_results();
    cfg_data_i  = len;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_len = len;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One session: maybe a fresh key, then a message. Key bytes that the
  // schedule will read are always loaded before any rekey, so no unwritten
  // store entry is ever read. A few noise words are mixed into the message.
  task automatic run_cipher_session();
    int unsigned n;
    int unsigned msg_len;
    int unsigned r;
    bit          reload;
    n       = active_key_len();
    reload  = ($urandom_range(99) < 35);
    if (reload) begin
      repeat ($urandom_range(1, 6))
        send_word(rc4_pkg::REQ_LOAD_KEY, 8'($urandom_range(n - 1)), 8'($urandom),
                  1'($urandom));
    end
    for (int k = 0; k < n; k++) begin
      if (!key_loaded[k]) begin
        send_word(rc4_pkg::REQ_LOAD_KEY, 8'(k), 8'($urandom), 1'($urandom));
        reload = 1'b1;
      end
    end
    if (reload || !is_keyed) begin
      send_word(rc4_pkg::REQ_REKEY, 8'($urandom), 8'($urandom), 1'($urandom));
    end
    msg_len = $urandom_range(1, 40);
    for (int m = 0; m < msg_len; m++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_word(REQ_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom));
      end else if (r < 6) begin
        send_word(rc4_pkg::REQ_LOAD_KEY, 8'($urandom), 8'($urandom), 1'($urandom));
      end else if (m == 0) begin
        // A message normally opens with new_message; now and then it does not.
        send_word(rc4_pkg::REQ_DATA, 8'($urandom), 8'($urandom),
                  $urandom_range(99) < 90);
      end else begin
        send_word(rc4_pkg::REQ_DATA, 8'($urandom), 8'($urandom),
                  $urandom_range(99) < 4);
      end
    end
  endtask

  // Sets a key length and runs sessions until the word budget is spent.
  task automatic run_key_length_phase(input logic [rc4_pkg::KEYLEN_W-1:0] len,
                                      input int unsigned budget,
                                      input bit steady);
    int unsigned target;
    write_key_length(len);
    steady_flow = steady;
    target      = words_sent + budget;
    while (words_sent < target) run_cipher_session();
    steady_flow = 1'b0;
  endtask

  // Before any key schedule the permutation is the identity; the unused
  // request code must leave everything alone.
  task automatic test_identity_before_key();
    send_word(rc4_pkg::REQ_DATA, 8'h00, 8'h00, 1'b0);
    send_word(rc4_pkg::REQ_DATA, 8'hFF, 8'hFF, 1'b1);
    send_word(REQ_UNUSED, 8'hFF, 8'hFF, 1'b1);
    send_word(rc4_pkg::REQ_DATA, 8'h5A, 8'hA5, 1'b0);
  endtask

  // Default key length of 16 with extreme key bytes, a load at the top
  // store index, a rekey and data right after it.
  task automatic test_default_key_schedule();
    write_key_length(rc4_pkg::KEYLEN_RESET);
    send_word(rc4_pkg::REQ_LOAD_KEY, 8'd0, 8'hFF, 1'b1);
    send_word(rc4_pkg::REQ_LOAD_KEY, 8'd1, 8'h00, 1'b0);
    for (int k = 2; k < 16; k++) begin
      send_word(rc4_pkg::REQ_LOAD_KEY, 8'(k), 8'($urandom), 1'b0);
    end
    send_word(rc4_pkg::REQ_LOAD_KEY, 8'd255, 8'hFF, 1'b0);
    send_word(rc4_pkg::REQ_REKEY, 8'hFF, 8'h00, 1'b1);
    send_word(rc4_pkg::REQ_DATA, 8'h00, 8'h00, 1'b1);
    send_word(rc4_pkg::REQ_DATA, 8'hFF, 8'hFF, 1'b0);
    send_word(REQ_UNUSED, 8'h00, 8'h00, 1'b0);
  endtask

  // Key length extremes: one byte, zero (acts as one), the whole store and
  // the largest register value (acts as the whole store). The first phase
  // runs with both sides never idling.
  task automatic test_key_length_extremes();
    run_key_length_phase(9'd1, 190, 1'b1);
    run_key_length_phase(9'd0, 190, 1'b0);
    run_key_length_phase(9'd256, 190, 1'b0);
    run_key_length_phase(9'h1FF, 190, 1'b0);
  endtask

  // Mixed traffic over further key lengths, random ones among them.
  task automatic test_random_traffic();
    run_key_length_phase(9'd2, 190, 1'b0);
    run_key_length_phase(9'd255, 190, 1'b0);
    run_key_length_phase(9'($urandom_range(3, 254)), 190, 1'b0);
    run_key_length_phase(9'($urandom_range(0, 511)), 190, 1'b0);
    run_key_length_phase(rc4_pkg::KEYLEN_RESET, 190, 1'b0);
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    steady_flow   = 1'b0;
    words_sent    = 0;
    errors        = 0;
    cycle_count   = 0;
    for (int k = 0; k < rc4_pkg::TABLE_SIZE; k++) sbox[k] = 8'(k);
    for (int k = 0; k < KEY_STORE_DEPTH; k++) begin
      key_bytes[k]  = '0;
      key_loaded[k] = 1'b0;
    end
    ptr_i    = '0;
    ptr_j    = '0;
    is_keyed = 1'b0;
    key_len  = rc4_pkg::KEYLEN_RESET;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_identity_before_key();
    test_default_key_schedule();
    test_key_length_extremes();
    test_random_traffic();

    drain_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_rc4_keystream_cipher_top: PASS");
    end else begin
      $display("tb_rc4_keystream_cipher_top: FAIL");
    end
    $finish;
  end

endmodule
